// ----- hw/rtl/mfbr_pkg.sv -----
// Shared types and constants for the MSB-first bit field reader.
`default_nettype none

package mfbr_pkg;

    localparam int BUFFER_BITS_DEFAULT    = 64;
    localparam int MAX_FIELD_BITS_DEFAULT = 32;
    localparam int QUEUE_DEPTH            = 2;

    localparam int BYTE_W        = 8;
    localparam int FIELD_LEN_W   = 6;
    localparam int STATUS_W      = 2;
    localparam int FIELD_W       = 32;
    localparam int BITS_HELD_W   = 7;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_BYTE_OK  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FIELD_OK = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_SHORT    = 2'd3;

    typedef struct packed {
        logic                   op;
        logic [BYTE_W-1:0]      data_byte;
        logic [FIELD_LEN_W-1:0] field_length;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [FIELD_W-1:0]     field_value;
        logic [BITS_HELD_W-1:0] bits_held;
    } out_item_t;

    typedef enum logic [1:0] {
        CMD_PUSH,
        CMD_READ,
        CMD_READ_NONE
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t              kind;
        logic [BYTE_W-1:0]      data_byte;
        logic [FIELD_LEN_W-1:0] field_length;
    } cmd_t;

endpackage

`default_nettype wire

// ----- hw/rtl/msb_first_bit_field_reader.sv -----
// Top level of the MSB-first bit field reader: front end, command queue and back end.
//
// Usage: each input item either pushes data_byte (op 0) onto the end of the bit
// buffer or reads the oldest field_length bits (op 1), most significant bit first.
// Every input item yields exactly one result item carrying a status, the extracted
// field value and the number of bits left in the buffer.
// Both channels use a valid/ready handshake. An item accepted at the input is
// written into the command queue, then executed into the result register, from
// which its result item can be taken.
// Throughput is one item per cycle while the receiver keeps taking results, set by
// the shift and mask step on the bit buffer in the back end.
// A two-entry command queue sits between front and back end; when the receiver
// stalls, the result register holds its item, the queue fills, and in_ready drops
// once it is full, with three items held in all. No item is lost or repeated.
// Reset empties the queue, clears the bit buffer and bit count, and drops out_valid.
`default_nettype none

module msb_first_bit_field_reader #(
    parameter int BUFFER_BITS    = mfbr_pkg::BUFFER_BITS_DEFAULT,
    parameter int MAX_FIELD_BITS = mfbr_pkg::MAX_FIELD_BITS_DEFAULT
) (
    input  var logic                clk,
    input  var logic                rst_n,
    input  var logic                in_valid,
    output var logic                in_ready,
    input  var mfbr_pkg::in_item_t  in_data,
    output var logic                out_valid,
    input  var logic                out_ready,
    output var mfbr_pkg::out_item_t out_data
);

    mfbr_pkg::cmd_t front_cmd;
    mfbr_pkg::cmd_t queue_cmd;
    logic           queue_valid;
    logic           queue_ready;

    mfbr_front #(
        .MAX_FIELD_BITS(MAX_FIELD_BITS)
    ) u_front (
        .item(in_data),
        .cmd (front_cmd)
    );

    mfbr_cmd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_valid(in_valid),
        .wr_ready(in_ready),
        .wr_cmd  (front_cmd),
        .rd_valid(queue_valid),
        .rd_ready(queue_ready),
        .rd_cmd  (queue_cmd)
    );

    mfbr_back #(
        .BUFFER_BITS(BUFFER_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(queue_valid),
        .cmd_ready(queue_ready),
        .cmd      (queue_cmd),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/mfbr_front.sv -----
// Front end: decodes each input item into a command and saturates the field length.
`default_nettype none

module mfbr_front #(
    parameter int MAX_FIELD_BITS = mfbr_pkg::MAX_FIELD_BITS_DEFAULT
) (
    input  var mfbr_pkg::in_item_t item,
    output var mfbr_pkg::cmd_t     cmd
);

    localparam logic [mfbr_pkg::FIELD_LEN_W-1:0] MAX_LEN =
        mfbr_pkg::FIELD_LEN_W'(MAX_FIELD_BITS);

    logic [mfbr_pkg::FIELD_LEN_W-1:0] len_sat;

    always_comb
    begin
        len_sat = (item.field_length > MAX_LEN) ? MAX_LEN : item.field_length;
        cmd.data_byte    = item.data_byte;
        cmd.field_length = len_sat;
        unique case (item.op)
            mfbr_pkg::OP_PUSH:
            begin
                cmd.kind = mfbr_pkg::CMD_PUSH;
            end
            default:
            begin
                cmd.kind = (len_sat == '0) ? mfbr_pkg::CMD_READ_NONE : mfbr_pkg::CMD_READ;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/mfbr_cmd_queue.sv -----
// Short command queue between the front end and the execution back end.
`default_nettype none

module mfbr_cmd_queue (
    input  var logic           clk,
    input  var logic           rst_n,
    input  var logic           wr_valid,
    output var logic           wr_ready,
    input  var mfbr_pkg::cmd_t wr_cmd,
    output var logic           rd_valid,
    input  var logic           rd_ready,
    output var mfbr_pkg::cmd_t rd_cmd
);

    localparam int DEPTH = mfbr_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    mfbr_pkg::cmd_t   mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign wr_ready = (count_reg != FULL_CNT);
    assign rd_valid = (count_reg != '0);
    assign rd_cmd   = mem[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/mfbr_back.sv -----
// Back end: holds the bit buffer, executes commands and registers each result item.
`default_nettype none

module mfbr_back #(
    parameter int BUFFER_BITS = mfbr_pkg::BUFFER_BITS_DEFAULT
) (
    input  var logic                clk,
    input  var logic                rst_n,
    input  var logic                cmd_valid,
    output var logic                cmd_ready,
    input  var mfbr_pkg::cmd_t      cmd,
    output var logic                out_valid,
    input  var logic                out_ready,
    output var mfbr_pkg::out_item_t out_data
);

    localparam int CNT_W = $clog2(BUFFER_BITS + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int FW    = mfbr_pkg::FIELD_W;
    localparam int BW    = mfbr_pkg::BYTE_W;

    logic [BUFFER_BITS-1:0] buffer_reg;
    logic [BUFFER_BITS-1:0] buffer_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    mfbr_pkg::out_item_t    out_data_reg;
    mfbr_pkg::out_item_t    out_data_next;

    logic                   fire;
    logic [CNT_W-1:0]       len;
    logic [CNT_W-1:0]       rest;
    logic [BUFFER_BITS-1:0] shifted;
    logic [FW-1:0]          value_mask;
    logic [FW-1:0]          value;
    logic [mfbr_pkg::STATUS_W-1:0] status;

    assign fire      = cmd_valid && (!out_valid_reg || out_ready);
    assign cmd_ready = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        len        = CNT_W'(cmd.field_length);
        rest       = count_reg - len;
        shifted    = buffer_reg >> rest;
        value_mask = ~({FW{1'b1}} << cmd.field_length);
        value      = '0;
        buffer_next = buffer_reg;
        count_next  = count_reg;
        unique case (cmd.kind)
            mfbr_pkg::CMD_PUSH:
            begin
                if ((SUM_W'(count_reg) + SUM_W'(BW)) > SUM_W'(BUFFER_BITS))
                begin
                    status = mfbr_pkg::STATUS_FULL;
                end
                else
                begin
                    status      = mfbr_pkg::STATUS_BYTE_OK;
                    buffer_next = {buffer_reg[BUFFER_BITS-BW-1:0], cmd.data_byte};
                    count_next  = count_reg + CNT_W'(BW);
                end
            end
            mfbr_pkg::CMD_READ:
            begin
                if (len > count_reg)
                begin
                    status = mfbr_pkg::STATUS_SHORT;
                end
                else
                begin
                    status      = mfbr_pkg::STATUS_FIELD_OK;
                    value       = shifted[FW-1:0] & value_mask;
                    count_next  = rest;
                    buffer_next = buffer_reg & ~({BUFFER_BITS{1'b1}} << rest);
                end
            end
            default:
            begin
                status = mfbr_pkg::STATUS_FIELD_OK;
            end
        endcase

        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (fire)
        begin
            out_valid_next            = 1'b1;
            out_data_next.status      = status;
            out_data_next.field_value = value;
            out_data_next.bits_held   = mfbr_pkg::BITS_HELD_W'(count_next);
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buffer_reg    <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                buffer_reg <= buffer_next;
                count_reg  <= count_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(BUFFER_BITS))
        else $error("bit count exceeds buffer size");

    a_stale_bits_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (buffer_reg >> count_reg) == '0)
        else $error("buffer holds bits above the bit count");

    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_data_reg.status != mfbr_pkg::STATUS_FIELD_OK)
        |-> out_data_reg.field_value == '0)
        else $error("field value nonzero without a valid field");

    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_data_reg.bits_held == mfbr_pkg::BITS_HELD_W'(count_reg))
        else $error("reported bits held differs from the bit count");

endmodule

`default_nettype wire

// ----- tb/sv/tb_msb_first_bit_field_reader.sv -----
// Self-checking testbench for the MSB-first bit field reader: directed table, then random traffic.
module tb_msb_first_bit_field_reader;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STREAM_BITS   = mfbr_pkg::BUFFER_BITS_DEFAULT;
    localparam int FIELD_MAX     = mfbr_pkg::MAX_FIELD_BITS_DEFAULT;
    localparam int BYTE_BITS     = mfbr_pkg::BYTE_W;
    localparam int LEN_W         = mfbr_pkg::FIELD_LEN_W;
    localparam int VALUE_W       = mfbr_pkg::FIELD_W;
    localparam int HELD_W        = mfbr_pkg::BITS_HELD_W;
    localparam int RANDOM_ITEMS  = 1430;
    localparam int DIRECTED_ROWS = 21;

    typedef struct packed {
        logic                    op;
        logic [BYTE_BITS-1:0]    data_byte;
        logic [LEN_W-1:0]        field_length;
        logic                    typed;
        mfbr_pkg::out_item_t     result;
    } dir_row_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    mfbr_pkg::in_item_t  in_data;
    logic                out_valid;
    logic                out_ready;
    mfbr_pkg::out_item_t out_data;

    logic [STREAM_BITS-1:0] stream_bits;
    logic [HELD_W-1:0]      stream_count;
    mfbr_pkg::out_item_t    expected_results [$];
    int                     results_seen;
    int                     errors;
    bit                     sender_quiet;

    // Typed rows give results that can be read straight off the stream contents.
    dir_row_t dir_rows [DIRECTED_ROWS] = '{
        '{mfbr_pkg::OP_READ, 8'h5C, 6'd1,  1'b1,
          '{mfbr_pkg::STATUS_SHORT,    32'd0,        7'd0}},
        '{mfbr_pkg::OP_READ, 8'h00, 6'd0,  1'b1,
          '{mfbr_pkg::STATUS_FIELD_OK, 32'd0,        7'd0}},
        '{mfbr_pkg::OP_PUSH, 8'hFF, 6'd63, 1'b1,
          '{mfbr_pkg::STATUS_BYTE_OK,  32'd0,        7'd8}},
        '{mfbr_pkg::OP_PUSH, 8'h00, 6'd0,  1'b1,
          '{mfbr_pkg::STATUS_BYTE_OK,  32'd0,        7'd16}},
        '{mfbr_pkg::OP_PUSH, 8'hA5, 6'd21, 1'b1,
          '{mfbr_pkg::STATUS_BYTE_OK,  32'd0,        7'd24}},
        '{mfbr_pkg::OP_PUSH, 8'h5A, 6'd42, 1'b1,
          '{mfbr_pkg::STATUS_BYTE_OK,  32'd0,        7'd32}},
        '{mfbr_pkg::OP_PUSH, 8'h80, 6'd1,  1'b1,
          '{mfbr_pkg::STATUS_BYTE_OK,  32'd0,        7'd40}},
        '{mfbr_pkg::OP_PUSH, 8'h01, 6'd32, 1'b1,
          '{mfbr_pkg::STATUS_BYTE_OK,  32'd0,        7'd48}},
        '{mfbr_pkg::OP_PUSH, 8'hC3, 6'd33, 1'b1,
          '{mfbr_pkg::STATUS_BYTE_OK,  32'd0,        7'd56}},
        '{mfbr_pkg::OP_PUSH, 8'h3C, 6'd7,  1'b1,
          '{mfbr_pkg::STATUS_BYTE_OK,  32'd0,        7'd64}},
        '{mfbr_pkg::OP_PUSH, 8'h77, 6'd0,  1'b1,
          '{mfbr_pkg::STATUS_FULL,     32'd0,        7'd64}},
        '{mfbr_pkg::OP_READ, 8'hFF, 6'd0,  1'b1,
          '{mfbr_pkg::STATUS_FIELD_OK, 32'd0,        7'd64}},
        '{mfbr_pkg::OP_READ, 8'h00, 6'd63, 1'b1,
          '{mfbr_pkg::STATUS_FIELD_OK, 32'hFF00A55A, 7'd32}},
        '{mfbr_pkg::OP_READ, 8'hAA, 6'd33, 1'b1,
          '{mfbr_pkg::STATUS_FIELD_OK, 32'h8001C33C, 7'd0}},
        '{mfbr_pkg::OP_READ, 8'h00, 6'd32, 1'b1,
          '{mfbr_pkg::STATUS_SHORT,    32'd0,        7'd0}},
        '{mfbr_pkg::OP_PUSH, 8'h96, 6'd5,  1'b0,
          '{mfbr_pkg::STATUS_BYTE_OK,  32'd0,        7'd0}},
        '{mfbr_pkg::OP_READ, 8'h00, 6'd1,  1'b0,
          '{mfbr_pkg::STATUS_BYTE_OK,  32'd0,        7'd0}},
        '{mfbr_pkg::OP_READ, 8'h00, 6'd7,  1'b0,
          '{mfbr_pkg::STATUS_BYTE_OK,  32'd0,        7'd0}},
        '{mfbr_pkg::OP_PUSH, 8'hF0, 6'd0,  1'b0,
          '{mfbr_pkg::STATUS_BYTE_OK,  32'd0,        7'd0}},
        '{mfbr_pkg::OP_READ, 8'h00, 6'd9,  1'b1,
          '{mfbr_pkg::STATUS_SHORT,    32'd0,        7'd8}},
        '{mfbr_pkg::OP_READ, 8'h00, 6'd8,  1'b1,
          '{mfbr_pkg::STATUS_FIELD_OK, 32'h000000F0, 7'd0}}
    };

    msb_first_bit_field_reader dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("tb_msb_first_bit_field_reader: FAIL");
        $finish;
    end

    function automatic logic [STREAM_BITS-1:0] low_ones(input int n);
        if (n >= STREAM_BITS)
            return '1;
        return (STREAM_BITS'(1) << n) - STREAM_BITS'(1);
    endfunction

    function automatic mfbr_pkg::out_item_t unpack_step(input mfbr_pkg::in_item_t it);
        mfbr_pkg::out_item_t res;
        int                  len;
        int                  rest;
        res = '0;
        if (it.op == mfbr_pkg::OP_PUSH)
        begin
            if (int'(stream_count) + 8 > STREAM_BITS)
            begin
                res.status = mfbr_pkg::STATUS_FULL;
            end
            else
            begin
                stream_bits  = (stream_bits << 8) | STREAM_BITS'(it.data_byte);
                stream_count = stream_count + HELD_W'(8);
                res.status   = mfbr_pkg::STATUS_BYTE_OK;
            end
        end
        else
        begin
            len = (int'(it.field_length) > FIELD_MAX) ? FIELD_MAX : int'(it.field_length);
            if (len > int'(stream_count))
            begin
                res.status = mfbr_pkg::STATUS_SHORT;
            end
            else
            begin
                res.status = mfbr_pkg::STATUS_FIELD_OK;
                if (len != 0)
                begin
                    rest            = int'(stream_count) - len;
                    res.field_value = VALUE_W'((stream_bits >> rest) & low_ones(len));
                    stream_count    = HELD_W'(rest);
                    stream_bits     = stream_bits & low_ones(rest);
                end
            end
        end
        res.bits_held = stream_count;
        return res;
    endfunction

    // Mostly well-formed traffic steered by the fill level, with some raw noise.
    function automatic mfbr_pkg::in_item_t random_item();
        mfbr_pkg::in_item_t it;
        int                 fill;
        int                 top;
        it.data_byte    = BYTE_BITS'($urandom_range(255));
        it.field_length = LEN_W'($urandom_range(63));
        fill = int'(stream_count);
        if ($urandom_range(99) < 10)
        begin
            it.op = 1'($urandom_range(1));
        end
        else
        begin
            if (fill <= 24)
                it.op = ($urandom_range(99) < 75) ? mfbr_pkg::OP_PUSH : mfbr_pkg::OP_READ;
            else if (fill >= 56)
                it.op = ($urandom_range(99) < 75) ? mfbr_pkg::OP_READ : mfbr_pkg::OP_PUSH;
            else
                it.op = 1'($urandom_range(1));
            if (it.op == mfbr_pkg::OP_READ && fill > 0)
            begin
                top = (fill > FIELD_MAX) ? FIELD_MAX : fill;
                it.field_length = LEN_W'($urandom_range(top, 1));
            end
        end
        return it;
    endfunction

    task automatic offer(input mfbr_pkg::in_item_t it, input bit typed,
                         input mfbr_pkg::out_item_t typed_res);
        mfbr_pkg::out_item_t res;
        while (!sender_quiet && $urandom_range(99) < 16)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        res = unpack_step(it);
        expected_results.push_back(typed ? typed_res : res);
        @(negedge clk);
    endtask

    initial
    begin
        mfbr_pkg::in_item_t it;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        stream_bits  = '0;
        stream_count = '0;
        errors       = 0;
        sender_quiet = 1'b0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        foreach (dir_rows[i])
        begin
            it.op           = dir_rows[i].op;
            it.data_byte    = dir_rows[i].data_byte;
            it.field_length = dir_rows[i].field_length;
            offer(it, dir_rows[i].typed, dir_rows[i].result);
        end
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            sender_quiet = (i >= 700 && i < 900);
            if (i == 1100)
            begin
                in_valid <= 1'b0;
                while (expected_results.size() != 0)
                    @(posedge clk);
                @(negedge clk);
            end
            offer(random_item(), 1'b0, '0);
        end
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("tb_msb_first_bit_field_reader: PASS");
        else
            $display("tb_msb_first_bit_field_reader: FAIL");
        $finish;
    end

    initial
    begin
        int  hold_left;
        bit  hold_done;
        out_ready = 1'b0;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (!hold_done && results_seen >= 300)
            begin
                out_ready <= 1'b0;
                hold_left = 200;
                hold_done = 1'b1;
            end
            else if (results_seen >= 700 && results_seen < 900)
            begin
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= 16);
            end
        end
    end

    initial results_seen = 0;

    always @(posedge clk)
    begin
        mfbr_pkg::out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                $error("result with no item outstanding: status %0d value %h held %0d",
                    out_data.status, out_data.field_value, out_data.bits_held);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (out_data.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, out_data.status);
                    errors++;
                end
                if (out_data.field_value !== want.field_value)
                begin
                    $error("field_value: expected %h, got %h",
                        want.field_value, out_data.field_value);
                    errors++;
                end
                if (out_data.bits_held !== want.bits_held)
                begin
                    $error("bits_held: expected %0d, got %0d",
                        want.bits_held, out_data.bits_held);
                    errors++;
                end
            end
        end
    end
endmodule
